### sv/rolsc_pkg.sv
package rolsc_pkg;

  // fixed field widths of the item and result words
  localparam int LABEL_W   = 10;
  localparam int WEIGHT_W  = 16;
  localparam int SCORE_W   = 44;
  localparam int OVERLAP_W = 24;
  localparam int SIZE_W    = 24;

  // weight after reset, 1.0 in Q8.8
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;

  typedef enum logic [1:0] {
    FUNC_GT_VOXEL   = 2'd0,
    FUNC_CAND_VOXEL = 2'd1,
    FUNC_FINISH     = 2'd2,
    FUNC_NO_ASSIGN  = 2'd3
  } func_t;

  typedef struct packed {
    func_t                func;
    logic [LABEL_W-1:0]   gt_label;
    logic                 in_region;
  } in_word_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] node_score;
    logic [OVERLAP_W-1:0]      best_overlap;
    logic [SIZE_W-1:0]         candidate_size;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LAST_CMP,
    ST_MUL,
    ST_DIFF
  } ctrl_state_t;

  // control from the sequencer to the scoring datapath
  typedef struct packed {
    logic clear;
    logic cmp_en;
    logic mul_en;
  } best_ctl_t;

endpackage

### sv/rolsc_in_if.sv
interface rolsc_in_if;
  import rolsc_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/rolsc_out_if.sv
interface rolsc_out_if;
  import rolsc_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/rolsc_ram.sv
module rolsc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word when the same entry is written in that cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/rolsc_best.sv
module rolsc_best #(
  parameter int COUNT_BITS       = 24,
  parameter int WEIGHT_FRAC_BITS = 8
) (
  input  logic                               clk,
  input  rolsc_pkg::best_ctl_t               ctl,
  input  logic [COUNT_BITS-1:0]              ov_rdata,
  input  logic [COUNT_BITS-1:0]              ls_rdata,
  input  logic [COUNT_BITS-1:0]              region_size,
  input  logic [rolsc_pkg::WEIGHT_W-1:0]     weight,
  output logic [COUNT_BITS-1:0]              best,
  output logic signed [rolsc_pkg::SCORE_W-1:0] score
);
  import rolsc_pkg::*;

  localparam int SUM_W  = COUNT_BITS + 1;
  localparam int FACT_W = WEIGHT_W + 2;
  localparam int POS_W  = SUM_W + WEIGHT_W;
  localparam int NEG_W  = COUNT_BITS + FACT_W;
  localparam logic [FACT_W-1:0] ONE = FACT_W'(1) << WEIGHT_FRAC_BITS;

  logic [COUNT_BITS-1:0] best_size;
  logic [SUM_W-1:0]      size_sum;
  logic [FACT_W-1:0]     factor;
  logic [POS_W-1:0]      prod_pos;
  logic [NEG_W-1:0]      prod_neg;

  assign size_sum = SUM_W'(region_size) + SUM_W'(best_size);
  assign factor   = {1'b0, weight, 1'b0} + ONE;

  // strict compare keeps the smaller label on a tie
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      best      <= '0;
      best_size <= '0;
    end else if (ctl.cmp_en && (ov_rdata > best)) begin
      best      <= ov_rdata;
      best_size <= ls_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_pos <= POS_W'(size_sum) * POS_W'(weight);
      prod_neg <= NEG_W'(best) * NEG_W'(factor);
    end
  end

  assign score = SCORE_W'(prod_pos) - SCORE_W'(prod_neg);

endmodule

### sv/region_overlap_loss_scorer_unit.sv
// channel  dir  port     word
// -------  ---  -------  -----------------------------------------------
// item     in   item     func, gt_label, in_region
// result   out  result   node_score, best_overlap, candidate_size
// config   in   cfg_wr_*  set_difference_weight, written on cfg_wr_en
//
// voxel words are taken one per cycle in idle; each is a read of one table
// entry and a write in the next cycle, with a bypass for back-to-back hits
// a finish word walks labels 1..LABEL_COUNT-1 through the table read port,
// so it holds the input until its result loads, as does a no-assignment word
// after rst a clearing pass over all LABEL_COUNT entries zeroes both tables,
// with the input held off
// a finished result sits in the output register; a stall there holds only
// the next finish or no-assignment word
module region_overlap_loss_scorer_unit #(
  parameter int LABEL_COUNT      = 1024,
  parameter int COUNT_BITS       = 24,
  parameter int WEIGHT_FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  rolsc_in_if.sink                       item,
  rolsc_out_if.source                    result,
  input  logic                           cfg_wr_en,
  input  logic [rolsc_pkg::WEIGHT_W-1:0] cfg_wr_data
);
  import rolsc_pkg::*;

  localparam int ADDR_W = $clog2(LABEL_COUNT);
  localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(LABEL_COUNT - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  ctrl_state_t state, state_next;

  logic [WEIGHT_W-1:0]   weight;
  logic [ADDR_W-1:0]     addr;           // clearing pass and scan pointer
  logic                  scan_rd;        // a scan read lands this cycle
  logic                  zero_sel;       // result is a no-assignment zero
  logic [COUNT_BITS-1:0] region_size;

  // voxel update stage
  logic                  p_valid;
  logic                  p_is_gt;
  logic [ADDR_W-1:0]     p_addr;
  logic                  fwd_valid;
  logic                  fwd_is_gt;
  logic [ADDR_W-1:0]     fwd_addr;
  logic [COUNT_BITS-1:0] fwd_data;
  logic                  fwd_hit;
  logic [COUNT_BITS-1:0] cur_value;
  logic [COUNT_BITS-1:0] upd_value;

  logic                  accept;
  logic                  label_ok;
  logic [ADDR_W-1:0]     label_addr;
  logic                  voxel_write;

  // table ports
  logic                  ls_we, ov_we;
  logic [ADDR_W-1:0]     ls_waddr, ov_waddr, tbl_raddr;
  logic [COUNT_BITS-1:0] ls_wdata, ov_wdata, ls_rdata, ov_rdata;

  logic                  in_ready;
  logic                  load;
  best_ctl_t             ctl;
  logic [COUNT_BITS-1:0] best;
  logic signed [SCORE_W-1:0] score;

  logic      out_valid;
  out_word_t out_data;

  assign item.ready   = in_ready;
  assign accept       = item.valid && in_ready;
  assign label_addr   = ADDR_W'(item.data.gt_label);
  assign label_ok     = (item.data.gt_label != '0) &&
                        (32'(item.data.gt_label) < LABEL_COUNT);
  // background and out-of-range labels and candidate voxels outside the mask touch no table
  assign voxel_write  = accept && label_ok &&
                        ((item.data.func == FUNC_GT_VOXEL) ||
                         ((item.data.func == FUNC_CAND_VOXEL) && item.data.in_region));

  assign result.valid = out_valid;
  assign result.data  = out_data;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= WEIGHT_RESET;
    end else if (cfg_wr_en) begin
      weight <= cfg_wr_data;
    end
  end

  // two tables, one entry per label
  rolsc_ram #(.WIDTH(COUNT_BITS), .DEPTH(LABEL_COUNT)) u_label_size (
    .clk   (clk),
    .we    (ls_we),
    .waddr (ls_waddr),
    .wdata (ls_wdata),
    .raddr (tbl_raddr),
    .rdata (ls_rdata)
  );

  rolsc_ram #(.WIDTH(COUNT_BITS), .DEPTH(LABEL_COUNT)) u_overlap (
    .clk   (clk),
    .we    (ov_we),
    .waddr (ov_waddr),
    .wdata (ov_wdata),
    .raddr (tbl_raddr),
    .rdata (ov_rdata)
  );

  // update stage: read issued on accept, write in the next cycle
  // the word written in the previous cycle has not reached the read data,
  // so a repeat of the same entry takes it from the bypass
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      p_valid   <= voxel_write;
      fwd_valid <= p_valid;
    end
    p_is_gt   <= (item.data.func == FUNC_GT_VOXEL);
    p_addr    <= label_addr;
    fwd_is_gt <= p_is_gt;
    fwd_addr  <= p_addr;
    fwd_data  <= upd_value;
  end

  assign fwd_hit   = fwd_valid && p_valid && (fwd_is_gt == p_is_gt) &&
                     (fwd_addr == p_addr);
  assign cur_value = fwd_hit ? fwd_data : (p_is_gt ? ls_rdata : ov_rdata);
  assign upd_value = sat_inc(cur_value);

  // candidate size counter, cleared when a finish result is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      region_size <= '0;
    end else if (load && !zero_sel) begin
      region_size <= '0;
    end else if (accept && (item.data.func == FUNC_CAND_VOXEL) && item.data.in_region) begin
      region_size <= sat_inc(region_size);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      addr    <= '0;
      scan_rd <= 1'b0;
    end else begin
      state   <= state_next;
      scan_rd <= (state == ST_SCAN);
      if ((state == ST_CLEAR) || (state == ST_SCAN)) begin
        addr <= addr + 1'b1;
      end else if (accept && (item.data.func == FUNC_FINISH)) begin
        addr <= ADDR_W'(1);    // label 0 is never scored
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      zero_sel <= (item.data.func == FUNC_NO_ASSIGN);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && (item.data.func == FUNC_FINISH)) begin
          state_next = ST_SCAN;
        end else if (accept && (item.data.func == FUNC_NO_ASSIGN)) begin
          state_next = ST_DIFF;
        end
      end
      ST_SCAN: begin
        if (addr == LAST_ADDR) begin
          state_next = ST_LAST_CMP;
        end
      end
      ST_LAST_CMP: state_next = ST_MUL;
      ST_MUL:      state_next = ST_DIFF;
      ST_DIFF: begin
        if (!out_valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    ls_we      = 1'b0;
    ov_we      = 1'b0;
    ls_waddr   = p_addr;
    ov_waddr   = p_addr;
    ls_wdata   = upd_value;
    ov_wdata   = upd_value;
    tbl_raddr  = label_addr;
    load       = 1'b0;
    ctl.clear  = 1'b0;
    ctl.cmp_en = scan_rd;
    ctl.mul_en = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ls_we    = 1'b1;
        ov_we    = 1'b1;
        ls_waddr = addr;
        ov_waddr = addr;
        ls_wdata = '0;
        ov_wdata = '0;
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        ls_we     = p_valid && p_is_gt;
        ov_we     = p_valid && !p_is_gt;
        ctl.clear = item.valid && (item.data.func == FUNC_FINISH);
      end
      ST_SCAN: begin
        // each overlap entry is read and zeroed in the same cycle
        tbl_raddr = addr;
        ov_we     = 1'b1;
        ov_waddr  = addr;
        ov_wdata  = '0;
      end
      ST_LAST_CMP: begin
      end
      ST_MUL: begin
        ctl.mul_en = 1'b1;
      end
      ST_DIFF: begin
        load = !out_valid || result.ready;
      end
      default: begin
      end
    endcase
  end

  rolsc_best #(
    .COUNT_BITS       (COUNT_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_best (
    .clk         (clk),
    .ctl         (ctl),
    .ov_rdata    (ov_rdata),
    .ls_rdata    (ls_rdata),
    .region_size (region_size),
    .weight      (weight),
    .best        (best),
    .score       (score)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (zero_sel) begin
        out_data <= '0;
      end else begin
        out_data.node_score     <= score;
        out_data.best_overlap   <= OVERLAP_W'(best);
        out_data.candidate_size <= SIZE_W'(region_size);
      end
    end
  end

  a_finish_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept && (item.data.func == FUNC_FINISH) |=> (state == ST_SCAN))
    else $error("finish word did not start the label scan");

  a_update_only_from_idle: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> ($past(state) == ST_IDLE))
    else $error("voxel update outside the idle state");

  a_bypass_needs_update: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> $past(p_valid) && p_valid)
    else $error("bypass hit without two back-to-back updates");

  a_size_cleared_after_finish: assert property (@(posedge clk) disable iff (rst)
    load && !zero_sel |=> (region_size == '0))
    else $error("candidate size not cleared after finish");

  a_load_shows_result: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("loaded result not presented");

endmodule

### tb/sv/rolsc_score_checker.sv
module rolsc_score_checker #(
  parameter int LABEL_COUNT      = 1024,
  parameter int COUNT_BITS       = 24,
  parameter int WEIGHT_FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  rolsc_in_if                            item_bus,
  rolsc_out_if                           result_bus,
  input  logic                           cfg_wr_en,
  input  logic [rolsc_pkg::WEIGHT_W-1:0] cfg_wr_data,
  output int                             mismatch_total,
  output int                             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import rolsc_pkg::*;

  logic [COUNT_BITS-1:0] gt_hist      [LABEL_COUNT];
  logic [COUNT_BITS-1:0] overlap_hist [LABEL_COUNT];
  logic [COUNT_BITS-1:0] region_count;
  logic [WEIGHT_W-1:0]   weight_q88;
  out_word_t             expected_scores [$];
  int                    bad_count;

  function automatic logic [COUNT_BITS-1:0] sat_bump(logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // fold one accepted word into the histograms, queue a score if it makes one
  function automatic void absorb_word(in_word_t w);
    logic [COUNT_BITS-1:0] best;
    logic [COUNT_BITS-1:0] best_gt;
    logic [63:0]           pos;
    logic [63:0]           neg;
    logic [63:0]           wide;
    logic                  label_ok;
    out_word_t             r;
    label_ok = (w.gt_label != '0) && (int'(w.gt_label) < LABEL_COUNT);
    case (w.func)
      FUNC_GT_VOXEL: begin
        if (label_ok) gt_hist[w.gt_label] = sat_bump(gt_hist[w.gt_label]);
      end
      FUNC_CAND_VOXEL: begin
        if (w.in_region) begin
          region_count = sat_bump(region_count);
          if (label_ok) overlap_hist[w.gt_label] = sat_bump(overlap_hist[w.gt_label]);
        end
      end
      FUNC_NO_ASSIGN: begin
        r = '0;
        expected_scores.push_back(r);
      end
      default: begin
        best    = '0;
        best_gt = '0;
        // strict compare so a tie keeps the smaller label
        for (int l = 1; l < LABEL_COUNT; l++) begin
          if (overlap_hist[l] > best) begin
            best    = overlap_hist[l];
            best_gt = gt_hist[l];
          end
        end
        pos  = 64'(region_count) * 64'(weight_q88) + 64'(best_gt) * 64'(weight_q88);
        neg  = (64'(weight_q88) * 64'd2 + (64'd1 << WEIGHT_FRAC_BITS)) * 64'(best);
        wide = pos - neg;
        r.node_score     = wide[SCORE_W-1:0];
        r.best_overlap   = OVERLAP_W'(best);
        r.candidate_size = SIZE_W'(region_count);
        expected_scores.push_back(r);
        for (int l = 0; l < LABEL_COUNT; l++) overlap_hist[l] = '0;
        region_count = '0;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    out_word_t got;
    if (rst) begin
      for (int l = 0; l < LABEL_COUNT; l++) begin
        gt_hist[l]      = '0;
        overlap_hist[l] = '0;
      end
      region_count = '0;
      weight_q88   = WEIGHT_RESET;
      expected_scores.delete();
    end else begin
      if (cfg_wr_en) weight_q88 = cfg_wr_data;
      // results first: a word never causes a result at the edge it is taken
      if (result_bus.valid && result_bus.ready) begin
        got = result_bus.data;
        if (expected_scores.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("unexpected result word: score %0d overlap %0d size %0d",
                     $signed(got.node_score), got.best_overlap, got.candidate_size);
        end else begin
          want = expected_scores.pop_front();
          if (got.node_score !== want.node_score || got.best_overlap !== want.best_overlap ||
              got.candidate_size !== want.candidate_size) begin
            bad_count++;
            if (bad_count <= 10)
              $display("result mismatch: expected score %0d overlap %0d size %0d, got %0d %0d %0d",
                       $signed(want.node_score), want.best_overlap, want.candidate_size,
                       $signed(got.node_score), got.best_overlap, got.candidate_size);
          end
        end
      end
      if (item_bus.valid && item_bus.ready) absorb_word(item_bus.data);
    end
    mismatch_total <= bad_count;
    outstanding    <= expected_scores.size();
  end

endmodule

### tb/sv/tb_region_overlap_loss_scorer_unit.sv
module tb_region_overlap_loss_scorer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rolsc_pkg::*;

  localparam int LABEL_COUNT = 1024;
  // a finish word walks the whole table; settle a little longer than that
  localparam int DRAIN_CYCLES = LABEL_COUNT + 16;
  // voxel words still in the table pipeline when the last score has come
  localparam int VOXEL_SETTLE = 16;
  localparam int LONG_HOLD = 2500;
  localparam int PHASE_COUNT = 7;
  localparam int PHASE_ITEMS = 110;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [WEIGHT_W-1:0] cfg_wr_data;
  int                  mismatch_total;
  int                  outstanding;

  // quiet and hold_req are set with nonblocking writes, read at later edges
  bit quiet;
  bit hold_req;
  bit rx_hold_done;
  int sent_words;

  rolsc_in_if  in_ch ();
  rolsc_out_if out_ch ();

  region_overlap_loss_scorer_unit #(
    .LABEL_COUNT     (LABEL_COUNT),
    .COUNT_BITS      (24),
    .WEIGHT_FRAC_BITS(8)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .item       (in_ch),
    .result     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  rolsc_score_checker #(
    .LABEL_COUNT     (LABEL_COUNT),
    .COUNT_BITS      (24),
    .WEIGHT_FRAC_BITS(8)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .item_bus      (in_ch),
    .result_bus    (out_ch),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .mismatch_total(mismatch_total),
    .outstanding   (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic in_word_t mk_word(func_t f, logic [LABEL_W-1:0] l, logic r);
    in_word_t w;
    w.func      = f;
    w.gt_label  = l;
    w.in_region = r;
    return w;
  endfunction

  // hold one word until taken; valid stays high unless a random gap drops it
  task automatic offer_word(in_word_t w);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    sent_words++;
  endtask

  // sender pause: drop valid and wait until every queued score has come back
  task automatic drain_scores(int extra);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic load_weight(logic [WEIGHT_W-1:0] w);
    drain_scores(VOXEL_SETTLE);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // one candidate: ground truth, masked voxels, rarely a no-assign, a finish
  task automatic send_candidate_run();
    logic [LABEL_W-1:0] pool [3];
    logic [LABEL_W-1:0] lbl;
    int                 n_gt;
    int                 n_cand;
    for (int k = 0; k < 3; k++) begin
      // a few low labels so label 1 and the background come up often
      if ($urandom_range(0, 7) == 0) pool[k] = LABEL_W'($urandom_range(0, 3));
      else pool[k] = LABEL_W'($urandom_range(0, LABEL_COUNT - 1));
    end
    n_gt   = $urandom_range(0, 6);
    n_cand = $urandom_range(0, 24);
    for (int k = 0; k < n_gt; k++) begin
      lbl = ($urandom_range(0, 4) == 0) ? LABEL_W'($urandom) : pool[$urandom_range(0, 2)];
      offer_word(mk_word(FUNC_GT_VOXEL, lbl, 1'($urandom)));
    end
    // small pool and short runs make overlap ties frequent
    for (int k = 0; k < n_cand; k++) begin
      lbl = ($urandom_range(0, 9) == 0) ? LABEL_W'($urandom) : pool[$urandom_range(0, 2)];
      offer_word(mk_word(FUNC_CAND_VOXEL, lbl, ($urandom_range(0, 4) != 0)));
    end
    if ($urandom_range(0, 9) == 0)
      offer_word(mk_word(FUNC_NO_ASSIGN, LABEL_W'($urandom), 1'($urandom)));
    offer_word(mk_word(FUNC_FINISH, LABEL_W'($urandom), 1'($urandom)));
  endtask

  // noise: a handful of words of any kind in any order
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++)
      offer_word(mk_word(func_t'($urandom_range(0, 3)), LABEL_W'($urandom), 1'($urandom)));
  endtask

  // result side: random stalls, one long hold-off on request, none when quiet
  initial begin
    forever begin
      if (hold_req && !rx_hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [WEIGHT_W-1:0] weight_plan [PHASE_COUNT];
    int                  phase_end;
    weight_plan[0] = 16'd0;
    weight_plan[1] = 16'hFFFF;
    weight_plan[2] = 16'd1;
    weight_plan[3] = WEIGHT_RESET;
    weight_plan[4] = WEIGHT_W'($urandom);
    weight_plan[5] = WEIGHT_W'($urandom_range(128, 1024));
    weight_plan[6] = WEIGHT_W'($urandom);

    rst         <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part, at the reset weight of 1.0
    // ground truth: label 3 twice, 5 once, top label once, background dropped
    offer_word(mk_word(FUNC_GT_VOXEL, 10'd3, 1'b0));
    offer_word(mk_word(FUNC_GT_VOXEL, 10'd3, 1'b1));
    offer_word(mk_word(FUNC_GT_VOXEL, 10'd5, 1'b0));
    offer_word(mk_word(FUNC_GT_VOXEL, 10'd1023, 1'b1));
    offer_word(mk_word(FUNC_GT_VOXEL, 10'd0, 1'b1));
    // three labels tie at one voxel each; the smallest, label 3, must win
    offer_word(mk_word(FUNC_CAND_VOXEL, 10'd5, 1'b1));
    offer_word(mk_word(FUNC_CAND_VOXEL, 10'd1023, 1'b1));
    offer_word(mk_word(FUNC_CAND_VOXEL, 10'd3, 1'b1));
    // background inside the mask counts toward size only
    offer_word(mk_word(FUNC_CAND_VOXEL, 10'd0, 1'b1));
    // voxels outside the mask change nothing
    offer_word(mk_word(FUNC_CAND_VOXEL, 10'd7, 1'b0));
    offer_word(mk_word(FUNC_CAND_VOXEL, 10'd1023, 1'b0));
    offer_word(mk_word(FUNC_FINISH, 10'd0, 1'b0));
    // finish right after a finish: empty candidate scores zero
    offer_word(mk_word(FUNC_FINISH, 10'd1023, 1'b1));
    offer_word(mk_word(FUNC_NO_ASSIGN, 10'd1023, 1'b1));
    // overlap with a label that has no ground truth
    offer_word(mk_word(FUNC_CAND_VOXEL, 10'd9, 1'b1));
    offer_word(mk_word(FUNC_CAND_VOXEL, 10'd9, 1'b1));
    offer_word(mk_word(FUNC_CAND_VOXEL, 10'd1, 1'b1));
    offer_word(mk_word(FUNC_FINISH, 10'd0, 1'b1));
    // no overlap at all: score is size times weight
    offer_word(mk_word(FUNC_CAND_VOXEL, 10'd0, 1'b1));
    offer_word(mk_word(FUNC_NO_ASSIGN, 10'd0, 1'b0));
    offer_word(mk_word(FUNC_FINISH, 10'd512, 1'b0));

    // random part, one weight per phase
    for (int p = 0; p < PHASE_COUNT; p++) begin
      load_weight(weight_plan[p]);
      if (p == PHASE_COUNT - 1) quiet <= 1'b1;
      if (p == 0) begin
        // receiver holds off while no-assignment words pile up at the input
        hold_req <= 1'b1;
        for (int k = 0; k < 8; k++) offer_word(mk_word(FUNC_NO_ASSIGN, 10'd0, 1'b0));
      end
      phase_end = sent_words + PHASE_ITEMS;
      while (sent_words < phase_end) begin
        if ($urandom_range(0, 6) == 0) send_noise();
        else send_candidate_run();
      end
    end

    drain_scores(DRAIN_CYCLES);
    if (mismatch_total == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog, well past the slowest legal run
  initial begin
    #(64'd50_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
sv/rolsc_pkg.sv
sv/rolsc_in_if.sv
sv/rolsc_out_if.sv
sv/rolsc_ram.sv
sv/rolsc_best.sv
sv/region_overlap_loss_scorer_unit.sv
tb/sv/rolsc_score_checker.sv
tb/sv/tb_region_overlap_loss_scorer_unit.sv
